### rtl/slg_pkg.sv
package slg_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] LEAD_FOLD  = 8'hC3;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [6:0] CH_HYPHEN = 7'h2D;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_UNDER  = 7'h5F;
    localparam logic [6:0] CH_0      = 7'h30;
    localparam logic [6:0] CH_9      = 7'h39;
    localparam logic [6:0] CH_UP_A   = 7'h41;
    localparam logic [6:0] CH_UP_Z   = 7'h5A;
    localparam logic [6:0] CH_LO_A   = 7'h61;
    localparam logic [6:0] CH_LO_Z   = 7'h7A;
    localparam logic [6:0] CH_C      = 7'h63;
    localparam logic [6:0] CH_E      = 7'h65;
    localparam logic [6:0] CH_I      = 7'h69;
    localparam logic [6:0] CH_N      = 7'h6E;
    localparam logic [6:0] CH_O      = 7'h6F;
    localparam logic [6:0] CH_U      = 7'h75;
    localparam logic [6:0] CH_Y      = 7'h79;
    localparam logic [6:0] CH_NONE   = 7'h00;

    // One queued entry: an optional hyphen to send first, then the character result.
    typedef struct packed {
        logic       hyph;
        logic [6:0] ch;
        logic       present;
        logic       done;
    } t_entry;

    // Base letter of a Latin-1 code point 0xC0..0xFF, given its low six bits.
    // Upper and lower case halves match except at the last code point.
    function automatic logic [6:0] fold_letter(input logic [5:0] idx);
        logic [6:0] r;
        case (idx[4:0])
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5:   r = CH_LO_A;
            5'd7:                                 r = CH_C;
            5'd8, 5'd9, 5'd10, 5'd11:             r = CH_E;
            5'd12, 5'd13, 5'd14, 5'd15:           r = CH_I;
            5'd17:                                r = CH_N;
            5'd18, 5'd19, 5'd20, 5'd21, 5'd22:    r = CH_O;
            5'd25, 5'd26, 5'd27, 5'd28:           r = CH_U;
            5'd29:                                r = CH_Y;
            5'd31:                                r = idx[5] ? CH_Y : CH_NONE;
            default:                              r = CH_NONE;
        endcase
        return r;
    endfunction

endpackage

### rtl/slg_if.sv
interface slg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_name;

    modport source (output valid, output in_byte, output end_of_name, input ready);
    modport sink   (input valid, input in_byte, input end_of_name, output ready);
endinterface

interface slg_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       char_present;
    logic       slug_done;

    modport source (output valid, output out_char, output char_present, output slug_done,
                    input ready);
    modport sink   (input valid, input out_char, input char_present, input slug_done,
                    output ready);
endinterface

### rtl/utf8_name_slugifier.sv
// Streaming slug generator for UTF-8 names.
// The i_in channel takes one byte of a name per item, with end_of_name set
// on the last byte. The o_out channel gives slug characters (a-z, 0-9 and
// hyphen) with char_present and slug_done. A byte yields no result, one
// character, or a hyphen followed by a character; the last byte of a name
// always yields at least one result, which carries slug_done.
// Each accepted byte is decoded in the cycle it is accepted and its results
// go into a two-entry queue, one entry per byte that has results. Entries
// are registered and offered on o_out in order. The input takes one
// byte per cycle while the queue holds fewer than two entries; a byte whose
// results include a hyphen is sent on the output as a hyphen and then its
// character, so that a stream of such bytes is held back by the single
// output port.
// When the receiver stalls, the queue fills and i_in.ready drops after two
// bytes are waiting; no result is lost or repeated.
// Synchronous reset clears the decoding state and empties the queue.
module utf8_name_slugifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slg_in_if.sink       i_in,
    slg_out_if.source    o_out
);

    // Decoding state.
    logic [1:0] r_skip, n_skip;
    logic       r_fold, n_fold;
    logic       r_seen, n_seen;
    logic       r_hpend, n_hpend;

    // Result queue.
    slg_pkg::t_entry r_q [slg_pkg::QUEUE_DEPTH];
    logic       r_head;
    logic [1:0] r_count, n_count;
    logic       r_hsent;

    logic            in_acc;
    logic            out_acc;
    logic            pop;
    logic            push;
    logic [6:0]      kept;
    logic            v_hpend;
    slg_pkg::t_entry new_entry;
    slg_pkg::t_entry head;
    logic [6:0]      b7;
    logic            tail;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign b7      = i_in.in_byte[6:0];

    // Byte decoding and next state.
    always_comb begin
        kept    = slg_pkg::CH_NONE;
        v_hpend = r_hpend;
        n_skip  = r_skip;
        n_fold  = r_fold;
        n_seen  = r_seen;
        if (r_skip != 2'd0) begin
            // Continuation byte, consumed whatever its value.
            if (r_fold) begin
                kept = slg_pkg::fold_letter(i_in.in_byte[5:0]);
            end
            n_fold = 1'b0;
            n_skip = r_skip - 2'd1;
        end else if (!i_in.in_byte[7]) begin
            if (b7 >= slg_pkg::CH_UP_A && b7 <= slg_pkg::CH_UP_Z) begin
                kept = b7 | 7'h20;
            end else if ((b7 >= slg_pkg::CH_LO_A && b7 <= slg_pkg::CH_LO_Z) ||
                         (b7 >= slg_pkg::CH_0 && b7 <= slg_pkg::CH_9)) begin
                kept = b7;
            end else if (b7 == slg_pkg::CH_SPACE || b7 == slg_pkg::CH_HYPHEN ||
                         b7 == slg_pkg::CH_UNDER) begin
                v_hpend = r_seen;
            end
        end else begin
            if ((i_in.in_byte & slg_pkg::LEAD2_MASK) == slg_pkg::LEAD2_CODE) begin
                n_skip = 2'd1;
            end else if ((i_in.in_byte & slg_pkg::LEAD3_MASK) == slg_pkg::LEAD3_CODE) begin
                n_skip = 2'd2;
            end else if ((i_in.in_byte & slg_pkg::LEAD4_MASK) == slg_pkg::LEAD4_CODE) begin
                n_skip = 2'd3;
            end
            n_fold = (i_in.in_byte == slg_pkg::LEAD_FOLD);
        end

        new_entry.hyph    = (kept != slg_pkg::CH_NONE) && v_hpend && r_seen;
        new_entry.ch      = kept;
        new_entry.present = (kept != slg_pkg::CH_NONE);
        new_entry.done    = i_in.end_of_name;

        n_hpend = v_hpend;
        if (kept != slg_pkg::CH_NONE) begin
            n_hpend = 1'b0;
            n_seen  = 1'b1;
        end
        if (i_in.end_of_name) begin
            // The name ends here: drop any open sequence and pending hyphen.
            n_skip  = 2'd0;
            n_fold  = 1'b0;
            n_seen  = 1'b0;
            n_hpend = 1'b0;
        end
    end

    assign push = in_acc && (new_entry.present || new_entry.done);

    // Output side: a hyphen entry is sent in two steps.
    assign head = r_q[r_head];
    assign pop  = out_acc && (!head.hyph || r_hsent);
    assign tail = r_head + r_count[0];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    assign i_in.ready     = (r_count < 2'(slg_pkg::QUEUE_DEPTH));
    assign o_out.valid    = (r_count != 2'd0);
    assign o_out.out_char = (head.hyph && !r_hsent) ? slg_pkg::CH_HYPHEN : head.ch;
    assign o_out.char_present = (head.hyph && !r_hsent) ? 1'b1 : head.present;
    assign o_out.slug_done    = (head.hyph && !r_hsent) ? 1'b0 : head.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip  <= 2'd0;
            r_fold  <= 1'b0;
            r_seen  <= 1'b0;
            r_hpend <= 1'b0;
            r_head  <= 1'b0;
            r_count <= 2'd0;
            r_hsent <= 1'b0;
        end else begin
            if (in_acc) begin
                r_skip  <= n_skip;
                r_fold  <= n_fold;
                r_seen  <= n_seen;
                r_hpend <= n_hpend;
            end
            r_count <= n_count;
            if (pop) begin
                r_head  <= ~r_head;
                r_hsent <= 1'b0;
            end else if (out_acc) begin
                r_hsent <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[tail] <= new_entry;
        end
    end

`ifndef NO_ASSERTIONS
    // The end of a name leaves the decoder in its reset state.
    a_name_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.end_of_name) |=> (r_skip == 2'd0 && !r_fold && !r_seen && !r_hpend))
        else $error("decoder state not cleared at end of name");

    // The queue never holds more entries than it has.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(slg_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // A hyphen is never the final result of a name.
    a_hyphen_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_char == slg_pkg::CH_HYPHEN) |-> !o_out.slug_done)
        else $error("hyphen carries slug_done");

    // The half-sent mark only stands on a queued hyphen entry.
    a_hsent_on_hyphen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hsent |-> (r_count != 2'd0 && head.hyph))
        else $error("hyphen mark without hyphen entry");
`endif

endmodule
